// ===== rtl/ssne_pkg.sv =====
package ssne_pkg;

  // Command codes
  localparam logic [2:0] CMD_DEC      = 3'd0;
  localparam logic [2:0] CMD_FIXED    = 3'd1;
  localparam logic [2:0] CMD_TIME     = 3'd2;
  localparam logic [2:0] CMD_HEX_WORD = 3'd3;
  localparam logic [2:0] CMD_HEX_BYTE = 3'd4;

  // Segment patterns: bit0..6 = a..g, bit7 = dot
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_DOT   = 8'h80;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  // Input and output word widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // Reciprocal of ten, exact for operands below 2**18
  localparam logic [35:0] RECIP_TEN  = 36'd52429;
  localparam int          RECIP_SHFT = 19;

  // Work carried down the pipeline
  typedef struct packed {
    logic [2:0]  cmd;
    logic        neg;
    logic        div;
    logic [16:0] mag;
    logic [3:0]  d0;
    logic [3:0]  d1;
    logic [3:0]  d2;
    logic [3:0]  dots;
    logic [15:0] raw;
  } stage_t;

  // Glyph for one hex digit
  function automatic logic [7:0] glyph(input logic [3:0] nib);
    logic [7:0] g;
    case (nib)
      4'h0: g = 8'h3F;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5B;
      4'h3: g = 8'h4F;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6D;
      4'h6: g = 8'h7D;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7F;
      4'h9: g = 8'h6F;
      4'hA: g = 8'h77;
      4'hB: g = 8'h7C;
      4'hC: g = 8'h39;
      4'hD: g = 8'h5E;
      4'hE: g = 8'h79;
      default: g = 8'h71;
    endcase
    return g;
  endfunction

  // Quotient by ten through a reciprocal multiply
  function automatic logic [16:0] div10(input logic [16:0] x);
    logic [35:0] p;
    p = 36'(x) * RECIP_TEN;
    return p[RECIP_SHFT+16:RECIP_SHFT];
  endfunction

  // Remainder given the quotient by ten
  function automatic logic [3:0] rem10(input logic [16:0] x, input logic [16:0] q);
    logic [16:0] r;
    r = x - {q[13:0], 3'b000} - {q[15:0], 1'b0};
    return r[3:0];
  endfunction

endpackage

// ===== rtl/seven_segment_number_encoder.sv =====
// Four-digit seven-segment number encoder.
// Input channel s_*: one command word per handshake, tdata holds from bit 0 up
// cmd[2:0], value[18:3], hours[23:19], minutes[29:24], seconds[35:30].
// Output channel m_*: one word of four segment patterns per command, digit one
// in bits 7:0 up to digit four in bits 31:24 (bit0..6 = a..g, bit7 = dot).
// Modes: signed decimal, one-decimal fixed point, time, hex word, hex byte;
// unused codes give a blank display.
// Six register stages (decode, fixed-point divide, three digit extraction
// stages, glyph output). Throughput: one word per cycle while the output is not
// stalled; each stage holds one reciprocal multiply by ten at most.
// Reset clears every stage valid bit; the payload is not cleared.
// When the receiver holds m_tready low, the output word is held and the stages
// behind it fill up; s_tready drops only once every stage is occupied, and no
// word is lost or repeated.
module seven_segment_number_encoder
  import ssne_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // cmd, value, hours, minutes, seconds (low to high), zero-filled
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // digit_one, digit_two, digit_three, digit_four segments (low to high)
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int NSTG = 5;

  logic [NSTG:0]         vld;
  logic [NSTG:0]         rdy;
  stage_t                pipe [NSTG];
  stage_t                pipe_next [NSTG];
  logic [OUT_DATA_W-1:0] out_word;
  logic [OUT_DATA_W-1:0] out_word_next;

  // Input fields
  logic [2:0]  in_cmd;
  logic [15:0] in_value;
  logic [4:0]  in_hours;
  logic [5:0]  in_minutes;
  logic [5:0]  in_seconds;

  assign in_cmd     = s_tdata[2:0];
  assign in_value   = s_tdata[18:3];
  assign in_hours   = s_tdata[23:19];
  assign in_minutes = s_tdata[29:24];
  assign in_seconds = s_tdata[35:30];

  // Stage advance: a stage loads when empty or when the one after it moves
  always_comb begin
    rdy[NSTG] = !vld[NSTG] || m_tready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NSTG];
  assign m_tdata  = out_word;

  // Decode: sign, magnitude, dots and divide flag
  logic        dec_neg;
  logic [16:0] dec_abs;
  logic        dec_big;
  logic [11:0] dec_time;
  logic [16:0] q2, q3, q4;

  always_comb begin
    dec_neg  = in_value[15];
    dec_abs  = dec_neg ? (17'd0 - {1'b1, in_value}) : {1'b0, in_value};
    dec_big  = ($signed(in_value) >= 16'sd1000) || ($signed(in_value) <= -16'sd100);
    dec_time = 12'(in_hours) * 12'd100 + 12'(in_minutes);

    pipe_next[0]      = '0;
    pipe_next[0].cmd  = in_cmd;
    pipe_next[0].raw  = in_value;
    pipe_next[0].neg  = dec_neg;
    pipe_next[0].mag  = dec_abs;
    case (in_cmd)
      CMD_FIXED: begin
        pipe_next[0].div  = dec_big;
        pipe_next[0].dots = dec_big ? 4'b0000 : 4'b0100;
      end
      CMD_TIME: begin
        pipe_next[0].neg  = 1'b0;
        pipe_next[0].mag  = 17'(dec_time);
        pipe_next[0].dots = in_seconds[0] ? 4'b1010 : 4'b0000;
      end
      default: begin
        pipe_next[0].div  = 1'b0;
      end
    endcase

    // Fixed point: truncate the magnitude by ten for large values
    pipe_next[1] = pipe[0];
    if (pipe[0].div) begin
      pipe_next[1].mag = div10(pipe[0].mag);
    end

    // Digit extraction: peel off units, tens and hundreds
    q2 = div10(pipe[1].mag);
    pipe_next[2]     = pipe[1];
    pipe_next[2].d0  = rem10(pipe[1].mag, q2);
    pipe_next[2].mag = q2;

    q3 = div10(pipe[2].mag);
    pipe_next[3]     = pipe[2];
    pipe_next[3].d1  = rem10(pipe[2].mag, q3);
    pipe_next[3].mag = q3;

    q4 = div10(pipe[3].mag);
    pipe_next[4]     = pipe[3];
    pipe_next[4].d2  = rem10(pipe[3].mag, q4);
    pipe_next[4].mag = q4;
  end

  // Output: thousands digit and glyph mapping
  logic [16:0] q5;
  logic [3:0]  d3;
  logic [7:0]  seg1, seg2, seg3, seg4;

  always_comb begin
    q5 = div10(pipe[4].mag);
    d3 = rem10(pipe[4].mag, q5);
    case (pipe[4].cmd)
      CMD_DEC, CMD_FIXED, CMD_TIME: begin
        seg1 = (pipe[4].neg ? SEG_MINUS : glyph(d3)) | (pipe[4].dots[0] ? SEG_DOT : SEG_BLANK);
        seg2 = glyph(pipe[4].d2) | (pipe[4].dots[1] ? SEG_DOT : SEG_BLANK);
        seg3 = glyph(pipe[4].d1) | (pipe[4].dots[2] ? SEG_DOT : SEG_BLANK);
        seg4 = glyph(pipe[4].d0) | (pipe[4].dots[3] ? SEG_DOT : SEG_BLANK);
      end
      CMD_HEX_WORD: begin
        seg1 = glyph(pipe[4].raw[15:12]);
        seg2 = glyph(pipe[4].raw[11:8]);
        seg3 = glyph(pipe[4].raw[7:4]);
        seg4 = glyph(pipe[4].raw[3:0]);
      end
      CMD_HEX_BYTE: begin
        seg1 = SEG_BLANK;
        seg2 = SEG_BLANK;
        seg3 = glyph(pipe[4].raw[7:4]);
        seg4 = glyph(pipe[4].raw[3:0]);
      end
      default: begin
        seg1 = SEG_BLANK;
        seg2 = SEG_BLANK;
        seg3 = SEG_BLANK;
        seg4 = SEG_BLANK;
      end
    endcase
    out_word_next = {seg4, seg3, seg2, seg1};
  end

  // Valid bits: advance with the data, clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i <= NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Payload: load on advance, hold on stall
  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      if (rdy[i]) begin
        pipe[i] <= pipe_next[i];
      end
    end
    if (rdy[NSTG]) begin
      out_word <= out_word_next;
    end
  end

  // Nothing is valid right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // An empty output stage lets every stage behind it move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output stage");

  // A stalled decode stage keeps its word
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !rdy[0] |=> vld[0] && $stable(pipe[0]))
    else $error("decode stage changed while stalled");

  // Hex byte words leave the two left digits blank
  a_hex_byte_blank: assert property (@(posedge clk) disable iff (rst)
    vld[4] && rdy[4] && pipe[4].cmd == CMD_HEX_BYTE |=> m_tdata[15:0] == 16'h0000)
    else $error("hex byte word with lit left digits");

endmodule

// ===== tb/seven_segment_number_encoder_test.sv =====
`timescale 1ns / 100ps

module seven_segment_number_encoder_test
  import ssne_pkg::*;
;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_PRINTED = 40;
  localparam int RANDOM_ITEMS = 1350;

  // Segment font for 0..F, digit 0 in the low byte
  localparam logic [127:0] HEX_FONT = {
    8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
    8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  logic [31:0] pending_segments [$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int          hold_cycles_req = 0;

  seven_segment_number_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up when the run takes far too long
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    return HEX_FONT[nib*8 +: 8];
  endfunction

  // Four digits of a signed number, leading zeros kept, minus on digit one
  function automatic logic [31:0] decimal_segments(input int num, input logic [3:0] dots);
    int         mag;
    logic [7:0] lead;
    logic [7:0] d2;
    logic [7:0] d3;
    logic [7:0] d4;
    if (num < 0) begin
      mag = -num;
      lead = SEG_MINUS;
    end else begin
      mag = num;
      lead = hex_glyph(4'((mag / 1000) % 10));
    end
    d2 = hex_glyph(4'((mag / 100) % 10));
    d3 = hex_glyph(4'((mag / 10) % 10));
    d4 = hex_glyph(4'(mag % 10));
    return {d4 | (dots[3] ? SEG_DOT : SEG_BLANK), d3 | (dots[2] ? SEG_DOT : SEG_BLANK),
            d2 | (dots[1] ? SEG_DOT : SEG_BLANK), lead | (dots[0] ? SEG_DOT : SEG_BLANK)};
  endfunction

  // Expected display word, digit one in the low byte
  function automatic logic [31:0] encode_display(input logic [2:0] op, input logic [15:0] raw,
                                                 input logic [4:0] hr, input logic [5:0] mn,
                                                 input logic [5:0] sec);
    int num;
    num = int'($signed(raw));
    case (op)
      CMD_DEC: return decimal_segments(num, 4'b0000);
      CMD_FIXED: begin
        // large values lose the fraction digit and the dot
        if (num >= 1000 || num <= -100) return decimal_segments(num / 10, 4'b0000);
        return decimal_segments(num, 4'b0100);
      end
      CMD_TIME:
        return decimal_segments(int'(hr) * 100 + int'(mn), sec[0] ? 4'b1010 : 4'b0000);
      CMD_HEX_WORD:
        return {hex_glyph(raw[3:0]), hex_glyph(raw[7:4]), hex_glyph(raw[11:8]),
                hex_glyph(raw[15:12])};
      CMD_HEX_BYTE:
        return {hex_glyph(raw[3:0]), hex_glyph(raw[7:4]), SEG_BLANK, SEG_BLANK};
      default: return {4{SEG_BLANK}};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (error_count < MAX_PRINTED)
      $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
    error_count++;
  endtask

  // Drive one command word and record its expected display on acceptance
  task automatic send_word(input logic [2:0] op, input logic [15:0] raw, input logic [4:0] hr,
                           input logic [5:0] mn, input logic [5:0] sec);
    int gap;
    gap = send_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, sec, mn, hr, raw, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_segments.push_back(encode_display(op, raw, hr, mn, sec));
  endtask

  // Hold input off until every expected word has come back
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
  endtask

  // Accept output words, with random stalls and requested long holds
  initial begin : accept_words
    int stall;
    int held;
    while (rst) @(posedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, 12) : 0;
      if (hold_cycles_req > 0) begin
        stall = stall + hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        for (held = 0; held < stall; held++) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Compare each accepted word against the oldest expectation
  always @(posedge clk) begin : check_words
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_segments.size() == 0) begin
        report_mismatch("unexpected word", 32'h0, m_tdata);
      end else begin
        want = pending_segments.pop_front();
        if (m_tdata[7:0] !== want[7:0])
          report_mismatch("digit_one_segments", 32'(want[7:0]), 32'(m_tdata[7:0]));
        if (m_tdata[15:8] !== want[15:8])
          report_mismatch("digit_two_segments", 32'(want[15:8]), 32'(m_tdata[15:8]));
        if (m_tdata[23:16] !== want[23:16])
          report_mismatch("digit_three_segments", 32'(want[23:16]), 32'(m_tdata[23:16]));
        if (m_tdata[31:24] !== want[31:24])
          report_mismatch("digit_four_segments", 32'(want[31:24]), 32'(m_tdata[31:24]));
      end
    end
  end

  task automatic test_signed_decimal();
    send_word(CMD_DEC, 16'd0, 5'd0, 6'd0, 6'd0);
    send_word(CMD_DEC, 16'd1234, 5'd0, 6'd0, 6'd0);
    send_word(CMD_DEC, 16'h7FFF, 5'd0, 6'd0, 6'd0);
    send_word(CMD_DEC, 16'hFFFF, 5'd0, 6'd0, 6'd0);
    // magnitude 32768 wraps its digits
    send_word(CMD_DEC, 16'h8000, 5'd31, 6'd63, 6'd63);
    send_word(CMD_DEC, 16'(-999), 5'd0, 6'd0, 6'd0);
  endtask

  task automatic test_fixed_point();
    send_word(CMD_FIXED, 16'd999, 5'd0, 6'd0, 6'd0);
    send_word(CMD_FIXED, 16'd1000, 5'd0, 6'd0, 6'd0);
    send_word(CMD_FIXED, 16'(-99), 5'd0, 6'd0, 6'd0);
    send_word(CMD_FIXED, 16'(-100), 5'd0, 6'd0, 6'd0);
    send_word(CMD_FIXED, 16'h7FFF, 5'd0, 6'd0, 6'd0);
    send_word(CMD_FIXED, 16'h8000, 5'd0, 6'd0, 6'd0);
    send_word(CMD_FIXED, 16'd0, 5'd0, 6'd0, 6'd0);
  endtask

  task automatic test_time_of_day();
    send_word(CMD_TIME, 16'd0, 5'd0, 6'd0, 6'd0);
    send_word(CMD_TIME, 16'hFFFF, 5'd23, 6'd59, 6'd59);
    send_word(CMD_TIME, 16'd0, 5'd12, 6'd34, 6'd1);
    // hours and minutes past their range
    send_word(CMD_TIME, 16'd0, 5'd31, 6'd63, 6'd62);
  endtask

  task automatic test_hex_and_blank();
    send_word(CMD_HEX_WORD, 16'h0123, 5'd0, 6'd0, 6'd0);
    send_word(CMD_HEX_WORD, 16'h89AB, 5'd0, 6'd0, 6'd0);
    send_word(CMD_HEX_WORD, 16'hCDEF, 5'd0, 6'd0, 6'd0);
    send_word(CMD_HEX_BYTE, 16'hFFA5, 5'd0, 6'd0, 6'd0);
    send_word(CMD_HEX_BYTE, 16'h0000, 5'd0, 6'd0, 6'd0);
    // unused codes blank the display
    send_word(3'd5, 16'h1234, 5'd7, 6'd7, 6'd7);
    send_word(3'd6, 16'hFFFF, 5'd31, 6'd63, 6'd63);
    send_word(3'd7, 16'h8000, 5'd1, 6'd1, 6'd1);
  endtask

  task automatic random_word();
    logic [2:0]  op;
    logic [15:0] raw;
    logic [4:0]  hr;
    logic [5:0]  mn;
    if ($urandom_range(0, 15) == 0) op = 3'($urandom_range(5, 7));
    else op = 3'($urandom_range(0, 4));
    // bias values toward the fixed-point thresholds and the extremes
    case ($urandom_range(0, 5))
      0: raw = 16'($urandom_range(990, 1010));
      1: raw = 16'(-int'($urandom_range(90, 110)));
      2: raw = 16'($urandom_range(0, 1100));
      3: raw = ($urandom_range(0, 1) == 1) ? 16'h8000 + 16'($urandom_range(0, 2))
                                          : 16'hFFFF - 16'($urandom_range(0, 2));
      default: raw = 16'($urandom);
    endcase
    hr = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
    mn = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
    send_word(op, raw, hr, mn, 6'($urandom_range(0, 63)));
  endtask

  // Stall the output long enough that the input stalls too, then drain
  task automatic test_backpressure();
    int n;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_cycles_req = 120;
    for (n = 0; n < 40; n++) random_word();
    wait_for_drain();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic test_random_commands();
    int n;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // change the idling pattern of both sides now and then
      if (n % 40 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      if (n % 337 == 336) wait_for_drain();
      random_word();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_signed_decimal();
    test_fixed_point();
    test_time_of_day();
    test_hex_and_blank();
    test_backpressure();
    test_random_commands();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
